// File: sv/tpd_pkg.sv
package tpd_pkg;

    // Report layout
    localparam int FIRST_RECORD = 3;
    localparam int RECORD_BYTES = 5;
    localparam int PART_W       = 3;

    // Default sizes of the report
    localparam int POINT_SLOTS_DEFAULT  = 10;
    localparam int REPORT_BYTES_DEFAULT = 80;

    // Coordinate arithmetic
    localparam int          COORD_W    = 15;
    localparam int          LIMIT_W    = 16;
    localparam int          COUNT_W    = 4;
    localparam logic [7:0]  AREA_MAX   = 8'd100;
    localparam logic [7:0]  AREA_SCALE = 8'd255;

    // Result kinds
    localparam logic KIND_POINT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Configuration register indexes
    localparam int         CFG_INDEX_W  = 2;
    localparam logic [1:0] REG_X_LIMIT    = 2'd0;
    localparam logic [1:0] REG_Y_LIMIT    = 2'd1;
    localparam logic [1:0] REG_MAX_POINTS = 2'd2;

    // Register reset values
    localparam logic [15:0] X_LIMIT_RESET    = 16'd799;
    localparam logic [15:0] Y_LIMIT_RESET    = 16'd1279;
    localparam logic [3:0]  MAX_POINTS_RESET = 4'd10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } report_item_t;

    typedef struct packed {
        logic               result_kind;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic [COUNT_W-1:0] point_index;
        logic [COUNT_W-1:0] point_count;
    } result_item_t;

endpackage

// File: sv/touch_report_point_decoder.sv
// Decodes a touch controller report that arrives one byte per item; an item with
// frame_start set is report byte 0 and restarts decoding. From byte 3 on, each of
// the first POINT_SLOTS 5-byte records whose two area bytes are at most 100 gives,
// if byte 0 is not zero, a point result with coordinates area*255+offset, clamped
// to x_limit and y_limit, at its y offset byte, until max_points points have been
// kept. The last report byte gives a summary result carrying the kept count; bytes
// after it are dropped until the next frame start. Each item passes through an
// input register and, if it makes a result, is then written into the output
// register; one item is taken every cycle while result_ready stays high. The only
// multiply is by the constant 255. Configuration writes are taken at once
// (cfg_ready is always high) and should happen while the block is idle.
module touch_report_point_decoder
    import tpd_pkg::*;
#(
    parameter int POINT_SLOTS  = POINT_SLOTS_DEFAULT,
    parameter int REPORT_BYTES = REPORT_BYTES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   report_valid,
    output logic                   report_ready,
    input  report_item_t           report_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_item_t           result_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]     cfg_data
);

    localparam int POS_W        = $clog2(REPORT_BYTES + 1);
    localparam int SLOT_W       = $clog2(POINT_SLOTS + 1);
    localparam int FIT_SLOTS    = (REPORT_BYTES - FIRST_RECORD - 1) / RECORD_BYTES;
    localparam int USABLE_SLOTS = (POINT_SLOTS < FIT_SLOTS) ? POINT_SLOTS : FIT_SLOTS;

    localparam logic [POS_W-1:0]  POS_IDLE  = POS_W'(REPORT_BYTES);
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(REPORT_BYTES - 1);
    localparam logic [POS_W-1:0]  POS_FIRST = POS_W'(FIRST_RECORD);
    localparam logic [POS_W-1:0]  POS_ONE   = POS_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_END  = SLOT_W'(USABLE_SLOTS);
    localparam logic [PART_W-1:0] PART_LAST = PART_W'(RECORD_BYTES - 1);
    localparam logic [PART_W-1:0] PART_XA   = PART_W'(0);
    localparam logic [PART_W-1:0] PART_XO   = PART_W'(1);
    localparam logic [PART_W-1:0] PART_YA   = PART_W'(2);
    localparam logic [PART_W-1:0] PART_YO   = PART_W'(3);

    // Configuration registers
    logic [LIMIT_W-1:0] x_limit_reg;
    logic [LIMIT_W-1:0] y_limit_reg;
    logic [COUNT_W-1:0] max_points_reg;

    // Input register
    logic         in_valid_reg;
    report_item_t in_item_reg;

    // Decode state
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [PART_W-1:0]  part_reg,   part_next;
    logic [SLOT_W-1:0]  slot_reg,   slot_next;
    logic               active_reg, active_next;
    logic [COUNT_W-1:0] kept_reg,   kept_next;
    logic [7:0]         x_area_reg, x_area_next;
    logic [7:0]         x_off_reg,  x_off_next;
    logic [7:0]         y_area_reg, y_area_next;

    // Output register
    logic         out_valid_reg;
    result_item_t out_item_reg;

    logic               out_free;
    logic               advance;
    logic               produce;
    result_item_t       result;
    logic [COORD_W-1:0] x_full;
    logic [COORD_W-1:0] y_full;
    logic [COORD_W-1:0] x_clamped;
    logic [COORD_W-1:0] y_clamped;
    logic               in_report;
    logic               in_record;
    logic               slot_ok;

    assign cfg_ready    = 1'b1;
    assign out_free     = !out_valid_reg || result_ready;
    assign advance      = in_valid_reg && out_free;
    assign report_ready = !in_valid_reg || out_free;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg    <= X_LIMIT_RESET;
            y_limit_reg    <= Y_LIMIT_RESET;
            max_points_reg <= MAX_POINTS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_LIMIT:    x_limit_reg    <= cfg_data;
                REG_Y_LIMIT:    y_limit_reg    <= cfg_data;
                REG_MAX_POINTS: max_points_reg <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Coordinates: area*255 + offset is at most 25755 for a kept record.
    assign x_full = COORD_W'(x_area_reg) * COORD_W'(AREA_SCALE) + COORD_W'(x_off_reg);
    assign y_full = COORD_W'(y_area_reg) * COORD_W'(AREA_SCALE)
                  + COORD_W'(in_item_reg.data_byte);
    assign x_clamped = ({1'b0, x_full} > x_limit_reg) ? x_limit_reg[COORD_W-1:0] : x_full;
    assign y_clamped = ({1'b0, y_full} > y_limit_reg) ? y_limit_reg[COORD_W-1:0] : y_full;

    assign in_report = pos_reg < POS_IDLE;
    assign in_record = pos_reg >= POS_FIRST;
    assign slot_ok   = slot_reg < SLOT_END;

    always_comb
    begin
        pos_next    = pos_reg;
        part_next   = part_reg;
        slot_next   = slot_reg;
        active_next = active_reg;
        kept_next   = kept_reg;
        x_area_next = x_area_reg;
        x_off_next  = x_off_reg;
        y_area_next = y_area_reg;
        produce     = 1'b0;
        result      = '0;

        if (in_item_reg.frame_start)
        begin
            active_next = in_item_reg.data_byte != 8'd0;
            kept_next   = '0;
            pos_next    = POS_ONE;
            part_next   = '0;
            slot_next   = '0;
        end
        else if (in_report)
        begin
            if (active_reg && in_record && slot_ok)
            begin
                unique case (part_reg)
                    PART_XA: x_area_next = in_item_reg.data_byte;
                    PART_XO: x_off_next  = in_item_reg.data_byte;
                    PART_YA: y_area_next = in_item_reg.data_byte;
                    PART_YO:
                    begin
                        if (x_area_reg <= AREA_MAX && y_area_reg <= AREA_MAX &&
                            kept_reg < max_points_reg)
                        begin
                            produce            = 1'b1;
                            result.result_kind = KIND_POINT;
                            result.x_coord     = x_clamped;
                            result.y_coord     = y_clamped;
                            result.point_index = kept_reg;
                            kept_next          = kept_reg + COUNT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end

            // A point never falls on the last byte, so the two results do not meet.
            if (pos_reg == POS_LAST)
            begin
                produce            = 1'b1;
                result.result_kind = KIND_SUMMARY;
                result.point_count = active_reg ? kept_reg : '0;
            end

            pos_next = pos_reg + POS_ONE;
            if (in_record)
            begin
                if (part_reg == PART_LAST)
                begin
                    part_next = '0;
                    if (slot_ok)
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
                else
                begin
                    part_next = part_reg + PART_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_IDLE;
            part_reg      <= '0;
            slot_reg      <= '0;
            active_reg    <= 1'b0;
            kept_reg      <= '0;
        end
        else
        begin
            if (report_valid && report_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                pos_reg    <= pos_next;
                part_reg   <= part_next;
                slot_reg   <= slot_next;
                active_reg <= active_next;
                kept_reg   <= kept_next;
            end

            if (advance && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (report_valid && report_ready)
        begin
            in_item_reg <= report_item;
        end
        if (advance)
        begin
            x_area_reg <= x_area_next;
            x_off_reg  <= x_off_next;
            y_area_reg <= y_area_next;
        end
        if (advance && produce)
        begin
            out_item_reg <= result;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_IDLE)
        else $error("byte position beyond the report length");

    assert property (@(posedge clk) disable iff (!rst_n)
        part_reg <= PART_LAST && slot_reg <= SLOT_END)
        else $error("record counters out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= COUNT_W'(USABLE_SLOTS))
        else $error("more points kept than record slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.result_kind == KIND_SUMMARY |->
            out_item_reg.x_coord == '0 && out_item_reg.point_index == '0)
        else $error("summary item carries point fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.result_kind == KIND_POINT |->
            out_item_reg.point_count == '0 && out_item_reg.point_index < kept_reg)
        else $error("point item inconsistent with kept count");

endmodule

// File: verif/tb_touch_report_point_decoder.sv
`timescale 1ns / 1ps

module tb_touch_report_point_decoder;
    import tpd_pkg::*;

    localparam int REPORT_LEN = REPORT_BYTES_DEFAULT;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS = 480;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // Predicts the points and summaries of the decoder and checks them in order.
    class point_decode_tracker;
        logic [LIMIT_W-1:0] x_limit;
        logic [LIMIT_W-1:0] y_limit;
        logic [COUNT_W-1:0] max_points;
        logic [6:0]         byte_pos;
        logic               active;
        logic [7:0]         x_area;
        logic [7:0]         x_offset;
        logic [7:0]         y_area;
        logic [COUNT_W-1:0] kept;
        result_item_t       pending_points[$];
        int                 bad_results;

        function new();
            x_limit = X_LIMIT_RESET;
            y_limit = Y_LIMIT_RESET;
            max_points = MAX_POINTS_RESET;
            byte_pos = 7'(REPORT_BYTES_DEFAULT);
            active = 1'b0;
            x_area = '0;
            x_offset = '0;
            y_area = '0;
            kept = '0;
            bad_results = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [LIMIT_W-1:0] value);
            case (index)
                REG_X_LIMIT:    x_limit = value;
                REG_Y_LIMIT:    y_limit = value;
                REG_MAX_POINTS: max_points = value[COUNT_W-1:0];
                default:        ;
            endcase
        endfunction

        function void note_byte(report_item_t item);
            int           rel;
            int           slot;
            int           part;
            int           rec_end;
            int unsigned  x;
            int unsigned  y;
            result_item_t outcome;
            if (item.frame_start)
            begin
                active = (item.data_byte != 8'd0);
                kept = '0;
                x_area = '0;
                x_offset = '0;
                y_area = '0;
                byte_pos = 7'd1;
                return;
            end
            if (byte_pos >= REPORT_BYTES_DEFAULT)
                return;
            outcome = '0;
            if (active && byte_pos >= FIRST_RECORD)
            begin
                rel = int'(byte_pos) - FIRST_RECORD;
                slot = rel / RECORD_BYTES;
                part = rel % RECORD_BYTES;
                rec_end = FIRST_RECORD + slot * RECORD_BYTES + RECORD_BYTES - 1;
                if (slot < POINT_SLOTS_DEFAULT && rec_end < REPORT_BYTES_DEFAULT - 1)
                begin
                    case (part)
                        0: x_area = item.data_byte;
                        1: x_offset = item.data_byte;
                        2: y_area = item.data_byte;
                        3:
                        begin
                            if (x_area <= AREA_MAX && y_area <= AREA_MAX && kept < max_points)
                            begin
                                x = 32'(x_area) * 32'(AREA_SCALE) + 32'(x_offset);
                                y = 32'(y_area) * 32'(AREA_SCALE) + 32'(item.data_byte);
                                if (x > x_limit)
                                    x = x_limit;
                                if (y > y_limit)
                                    y = y_limit;
                                outcome.result_kind = KIND_POINT;
                                outcome.x_coord = x[COORD_W-1:0];
                                outcome.y_coord = y[COORD_W-1:0];
                                outcome.point_index = kept;
                                pending_points.push_back(outcome);
                                kept = kept + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (byte_pos == REPORT_BYTES_DEFAULT - 1)
            begin
                outcome = '0;
                outcome.result_kind = KIND_SUMMARY;
                outcome.point_count = active ? kept : '0;
                pending_points.push_back(outcome);
            end
            byte_pos = byte_pos + 1'b1;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                bad_results++;
                if (bad_results <= 100)
                    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(result_item_t got);
            result_item_t want;
            if (pending_points.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 100)
                    $display("%0t: unexpected result, expected none, actual kind %0d x %0d y %0d",
                             $time, got.result_kind, got.x_coord, got.y_coord);
                return;
            end
            want = pending_points.pop_front();
            compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
            compare_field("x_coord", 16'(want.x_coord), 16'(got.x_coord));
            compare_field("y_coord", 16'(want.y_coord), 16'(got.y_coord));
            compare_field("point_index", 16'(want.point_index), 16'(got.point_index));
            compare_field("point_count", 16'(want.point_count), 16'(got.point_count));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   report_valid;
    logic                   report_ready;
    report_item_t           report_item;
    logic                   result_valid;
    logic                   result_ready;
    result_item_t           result_item;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0]     cfg_data;

    point_decode_tracker tracker;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    logic [7:0]          frame_bytes [REPORT_LEN];

    touch_report_point_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report_item  (report_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.check_result(result_item);
    end

    // All driving tasks are entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] data, input logic start);
        report_item_t item;
        item.data_byte = data;
        item.frame_start = start;
        while ($urandom_range(99) < send_idle_pct)
        begin
            report_valid <= 1'b0;
            @(negedge clk);
        end
        report_valid <= 1'b1;
        report_item <= item;
        @(posedge clk);
        while (!report_ready)
            @(posedge clk);
        tracker.note_byte(item);
        @(negedge clk);
    endtask

    // Stops sending and waits until every expected result has come out.
    task automatic wait_for_idle();
        report_valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending_points.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_register(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(1500));
            1:       return 16'($urandom_range(25755));
            2:       return 16'($urandom);
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic write_random_limits();
        write_register(REG_X_LIMIT, pick_limit());
        write_register(REG_Y_LIMIT, pick_limit());
        if ($urandom_range(4) == 0)
            write_register(REG_MAX_POINTS, 16'($urandom_range(15)));
        else
            write_register(REG_MAX_POINTS, 16'($urandom_range(10, 1)));
    endtask

    // Builds a report with random records; area bytes exceed 100 at the given rate.
    task automatic fill_report(input bit empty, input int bad_pct);
        int part;
        frame_bytes[0] = empty ? 8'd0 : 8'($urandom_range(255, 1));
        for (int p = 1; p < REPORT_LEN; p++)
        begin
            part = (p - FIRST_RECORD) % RECORD_BYTES;
            if (p >= FIRST_RECORD && (part == 0 || part == 2))
                frame_bytes[p] = ($urandom_range(99) < bad_pct) ? 8'($urandom_range(255, 101))
                                                                 : 8'($urandom_range(100));
            else
                frame_bytes[p] = 8'($urandom);
        end
    endtask

    function automatic void put_record(int slot, logic [7:0] xa, logic [7:0] xo,
                                       logic [7:0] ya, logic [7:0] yo);
        frame_bytes[FIRST_RECORD + slot * RECORD_BYTES]     = xa;
        frame_bytes[FIRST_RECORD + slot * RECORD_BYTES + 1] = xo;
        frame_bytes[FIRST_RECORD + slot * RECORD_BYTES + 2] = ya;
        frame_bytes[FIRST_RECORD + slot * RECORD_BYTES + 3] = yo;
    endfunction

    task automatic send_span(input int first, input int last);
        for (int p = first; p <= last; p++)
            send_byte(frame_bytes[p], p == 0);
    endtask

    task automatic run_directed();
        // Bytes before any frame start are dropped.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        // Corner coordinates and area bytes either side of the drop threshold.
        fill_report(1'b0, 0);
        frame_bytes[0] = 8'hFF;
        put_record(0, 8'd0, 8'd0, 8'd0, 8'd0);
        put_record(1, 8'd100, 8'd255, 8'd100, 8'd255);
        put_record(2, 8'd101, 8'd0, 8'd50, 8'd0);
        put_record(3, 8'd50, 8'd0, 8'd101, 8'd0);
        put_record(4, 8'd3, 8'd34, 8'd5, 8'd4);
        put_record(5, 8'd3, 8'd35, 8'd5, 8'd5);
        put_record(6, 8'd255, 8'd255, 8'd255, 8'd255);
        send_span(0, REPORT_LEN - 1);

        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);

        // The limits change half-way through a record, then the report is cut short.
        fill_report(1'b0, 0);
        frame_bytes[0] = 8'h01;
        put_record(0, 8'd10, 8'd20, 8'd30, 8'd40);
        put_record(1, 8'd100, 8'd255, 8'd100, 8'd255);
        put_record(2, 8'd90, 8'd200, 8'd90, 8'd200);
        send_span(0, 10);
        wait_for_idle();
        write_register(REG_X_LIMIT, 16'hFFFF);
        write_register(REG_Y_LIMIT, 16'd25755);
        write_register(REG_UNUSED, 16'hFFFF);
        send_span(11, 20);

        // An empty report restarts the one above and still gives its summary.
        fill_report(1'b1, 0);
        send_span(0, REPORT_LEN - 1);

        wait_for_idle();
        write_register(REG_MAX_POINTS, 16'd0);
        fill_report(1'b0, 0);
        send_span(0, REPORT_LEN - 1);
    endtask

    task automatic run_random(input int phase_no);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                fill_report(1'b1, 0);
                send_span(0, REPORT_LEN - 1);
                sent += REPORT_LEN;
            end
            else if (pick < 20)
            begin
                // Left unfinished; the next frame start abandons it.
                len = $urandom_range(REPORT_LEN - 1, 1);
                fill_report(1'b0, $urandom_range(40));
                send_span(0, len - 1);
                sent += len;
            end
            else if (pick < 26)
            begin
                repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
            end
            else
            begin
                fill_report(1'b0, $urandom_range(60));
                send_span(0, REPORT_LEN - 1);
                sent += REPORT_LEN;
            end
            if ($urandom_range(5) == 0)
            begin
                wait_for_idle();
                if (phase_no == 2)
                    write_random_limits();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        report_valid = 1'b0;
        report_item = '0;
        result_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_X_LIMIT;
        cfg_data = '0;
        tracker = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 28;
        recv_idle_pct = 48;
        run_directed();

        for (int phase_no = 0; phase_no < 3; phase_no++)
        begin
            wait_for_idle();
            case (phase_no)
                0:
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 48;
                    write_register(REG_X_LIMIT, 16'd0);
                    write_register(REG_Y_LIMIT, 16'd25755);
                    write_register(REG_MAX_POINTS, 16'd1);
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 28;
                    write_register(REG_X_LIMIT, 16'hFFFF);
                    write_register(REG_Y_LIMIT, 16'd0);
                    write_register(REG_MAX_POINTS, 16'd15);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_random_limits();
                end
            endcase
            run_random(phase_no);
        end

        wait_for_idle();
        if (tracker.bad_results == 0 && tracker.pending_points.size() == 0)
            $display("PASS touch_report_point_decoder");
        else
            $display("FAIL touch_report_point_decoder");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL touch_report_point_decoder");
        $finish;
    end

endmodule
